[rtl/srss_pkg.sv]
// Shared types and codes for the slice refresh serve scheduler.
// No dependencies; every other file of the block imports it.
package srss_pkg;

  localparam int SLOT_W = 6;   // slot number field
  localparam int N_W    = 7;   // slice count, refresh rate
  localparam int SUM_W  = 8;   // pointer plus rate, window arithmetic
  localparam int CIDX_W = 2;   // configuration register index

  localparam logic [1:0] MODE_MERGE   = 2'd0;
  localparam logic [1:0] MODE_ENCODED = 2'd1;
  localparam logic [1:0] MODE_REFRESH = 2'd2;
  localparam logic [1:0] MODE_SERVE   = 2'd3;

  localparam logic [CIDX_W-1:0] REG_SLICES  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_RATE    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SVC     = 2'd2;

  localparam logic [N_W-1:0] SLICES_RESET = 7'd64;
  localparam logic [N_W-1:0] RATE_RESET   = 7'd5;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SLOT_W-1:0] slice_index;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_number;
    logic              serve;
    logic              is_refresh;
    logic              nothing_ready;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic serve;
    logic is_refresh;
  } dec_t;

endpackage

[rtl/srss_if.sv]
// Handshake channel interfaces: request, result and configuration write.
// Depends on srss_pkg for the payload types.
interface srss_req_if import srss_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface srss_rsp_if import srss_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface srss_cfg_if import srss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [N_W-1:0]    wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

[rtl/srss_slot_eval.sv]
// Per-slot serve decision, shared by every step of the walk.
// Depends on srss_pkg.
module srss_slot_eval import srss_pkg::*; (
  input  logic              present,
  input  logic              fresh,
  input  logic [SLOT_W-1:0] slot,
  input  logic [N_W-1:0]    count,
  input  logic [SLOT_W-1:0] pointer,
  input  logic [N_W-1:0]    rate,
  input  logic              svc,
  input  logic              full,
  output dec_t              dec
);

  logic [SUM_W-1:0] m;
  logic [SUM_W-1:0] win_lo;
  logic [SUM_W-1:0] win_hi;
  logic             in_win;

  always_comb begin
    win_lo = SUM_W'(pointer);
    win_hi = SUM_W'(pointer) + SUM_W'(rate);
    // unwrap slots behind the pointer so the window is one linear range
    m = SUM_W'(slot) + ((slot < pointer) ? SUM_W'(count) : '0);
    in_win = (m >= win_lo) && (m < win_hi);
    dec = '0;
    if (!present) begin
      dec = '0;
    end else if (!svc && slot == '0) begin
      dec.serve = 1'b1;
    end else if (fresh) begin
      dec.serve = 1'b1;
    end else if (in_win) begin
      dec.serve      = 1'b1;
      dec.is_refresh = 1'b1;
    end else begin
      dec.serve = full;
    end
  end

endmodule

[rtl/srss_rem.sv]
// Iterative remainder unit: one shift-compare-subtract step per cycle.
// Depends on srss_pkg.
module srss_rem import srss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [N_W-1:0]    divisor,
  output logic              done,
  output logic [SLOT_W-1:0] result
);

  localparam int SH_W = SUM_W + N_W;
  localparam int K_W  = $clog2(SUM_W);

  logic             busy;
  logic [K_W-1:0]   k;
  logic [SUM_W-1:0] rem;
  logic [N_W-1:0]   div;
  logic [SH_W-1:0]  shifted;
  logic [SH_W-1:0]  diff;

  always_comb begin
    shifted = SH_W'(div) << k;
    diff    = SH_W'(rem) - shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= K_W'(SUM_W - 1);
        rem  <= dividend;
        div  <= divisor;
      end else if (busy) begin
        if (SH_W'(rem) >= shifted) begin
          rem <= diff[SUM_W-1:0];
        end
        if (k == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - 1'b1;
        end
      end
    end
  end

  assign result = rem[SLOT_W-1:0];

endmodule

[rtl/slice_refresh_serve_scheduler.sv]
// Slice refresh serve scheduler. Merge, encode-done and refresh items are handled in the idle state.
// A serve item walks the slots in use, one result per cycle through the single slot
// evaluator while the output is not stalled, then updates the refresh pointer in the
// remainder unit. Before any encode, a serve gives one nothing-ready result. Reset
// (synchronous) clears all slot bits, pointer and flags and loads the register defaults.
module slice_refresh_serve_scheduler import srss_pkg::*; #(
  parameter int MAX_SLICES = 64
) (
  input  logic            clk,
  input  logic            rst,
  srss_req_if.sink        req,
  srss_rsp_if.source      rsp,
  srss_cfg_if.sink        cfg
);

  localparam int IDX_W = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_NRDY = 2'd2;
  localparam logic [1:0] ST_MOD  = 2'd3;

  logic [1:0]            state;
  logic [MAX_SLICES-1:0] present;
  logic [MAX_SLICES-1:0] fresh;
  logic [SLOT_W-1:0]     pointer;
  logic                  full;
  logic                  encoded;
  logic [N_W-1:0]        slices;
  logic [N_W-1:0]        rate;
  logic                  svc;
  logic [SLOT_W-1:0]     slot;
  logic                  out_valid;
  rsp_t                  out_data;

  logic [N_W-1:0]        count;
  logic                  emit;
  logic                  out_load;
  logic                  walk_end;
  logic                  rem_start;
  logic                  rem_done;
  logic [SLOT_W-1:0]     rem_result;
  dec_t                  dec;
  logic                  merge_ok;

  always_comb begin
    if (slices == '0) begin
      count = N_W'(1);
    end else if (slices > N_W'(MAX_SLICES)) begin
      count = N_W'(MAX_SLICES);
    end else begin
      count = slices;
    end
    emit      = !out_valid || rsp.ready;
    out_load  = emit && ((state == ST_WALK) || (state == ST_NRDY));
    walk_end  = (N_W'(slot) + N_W'(1)) == count;
    rem_start = (state == ST_WALK) && emit && walk_end;
    merge_ok  = N_W'(req.data.slice_index) < count;
  end

  srss_slot_eval u_eval (
    .present (present[slot[IDX_W-1:0]]),
    .fresh   (fresh[slot[IDX_W-1:0]]),
    .slot    (slot),
    .count   (count),
    .pointer (pointer),
    .rate    (rate),
    .svc     (svc),
    .full    (full),
    .dec     (dec)
  );

  srss_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (SUM_W'(pointer) + SUM_W'(rate)),
    .divisor  (count),
    .done     (rem_done),
    .result   (rem_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      present   <= '0;
      fresh     <= '0;
      pointer   <= '0;
      full      <= 1'b0;
      encoded   <= 1'b0;
      slices    <= SLICES_RESET;
      rate      <= RATE_RESET;
      svc       <= 1'b0;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_SLICES: slices <= cfg.wdata;
          REG_RATE:   rate   <= cfg.wdata;
          REG_SVC:    svc    <= cfg.wdata[0];
          default:    ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            unique case (req.data.mode)
              MODE_MERGE: begin
                if (merge_ok) begin
                  present[req.data.slice_index[IDX_W-1:0]] <= 1'b1;
                  fresh[req.data.slice_index[IDX_W-1:0]]   <= 1'b1;
                end
              end
              MODE_ENCODED: encoded <= 1'b1;
              MODE_REFRESH: full    <= 1'b1;
              MODE_SERVE: begin
                slot  <= '0;
                state <= encoded ? ST_WALK : ST_NRDY;
              end
              default: ;
            endcase
          end
        end
        ST_NRDY: begin
          if (emit) begin
            // slot 0, not served, nothing ready, last
            out_data <= {{SLOT_W{1'b0}}, 1'b0, 1'b0, 1'b1, 1'b1};
            state    <= ST_IDLE;
          end
        end
        ST_WALK: begin
          if (emit) begin
            out_data               <= {slot, dec.serve, dec.is_refresh, 1'b0, walk_end};
            // age each slot as it is walked
            fresh[slot[IDX_W-1:0]] <= 1'b0;
            if (walk_end) begin
              full  <= 1'b0;
              state <= ST_MOD;
            end else begin
              slot <= slot + 1'b1;
            end
          end
        end
        ST_MOD: begin
          if (rem_done) begin
            pointer <= rem_result;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule
